/* rtl/tkpc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkpc_pkg
// Shared types, register map and event codes of the three-key press
// classifier.
// ----------------------------------------------------------------------------
package tkpc_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int CFG_W           = 16;
    localparam int PADDR_W         = 3;
    localparam int PDATA_W         = 32;
    localparam int IN_TDATA_W      = 8;
    localparam int OUT_TDATA_W     = 8;

    localparam logic [CFG_W-1:0] LONG_THRESHOLD_RST = 16'd200;
    localparam logic [CFG_W-1:0] REPEAT_RELOAD_RST  = 16'd170;

    // Register byte addresses.
    localparam logic [PADDR_W-1:0] ADDR_LONG_THRESHOLD = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_REPEAT_RELOAD  = 3'd4;

    // UI modes.
    localparam logic [1:0] MODE_CLOCK = 2'd0;
    localparam logic [1:0] MODE_TIMER = 2'd1;
    localparam logic [1:0] MODE_POWER = 2'd2;

    // Mode key events.
    localparam logic [2:0] MEV_NONE          = 3'd0;
    localparam logic [2:0] MEV_SWITCH_MODE   = 3'd1;
    localparam logic [2:0] MEV_ENTER_SETTING = 3'd2;
    localparam logic [2:0] MEV_LEAVE_SETTING = 3'd3;
    localparam logic [2:0] MEV_POWER_TOGGLE  = 3'd4;

    // Select key events.
    localparam logic [1:0] SEV_NONE         = 2'd0;
    localparam logic [1:0] SEV_CHOOSE_DIGIT = 2'd1;
    localparam logic [1:0] SEV_DISPLAY_MODE = 2'd2;
    localparam logic [1:0] SEV_COUNT_DIR    = 2'd3;

    // Increment key events.
    localparam logic [1:0] IEV_NONE        = 2'd0;
    localparam logic [1:0] IEV_INC_DIGIT   = 2'd1;
    localparam logic [1:0] IEV_TIMER_START = 2'd2;
    localparam logic [1:0] IEV_TIMER_RESET = 2'd3;

    typedef struct packed {
        logic       keys_locked;
        logic       clock_setting;
        logic [1:0] ui_mode;
        logic       select_key_pressed;
        logic       inc_key_pressed;
        logic       mode_key_pressed;
    } t_scan_item;

    typedef struct packed {
        logic [1:0] inc_key_event;
        logic [1:0] select_key_event;
        logic [2:0] mode_key_event;
    } t_events;

    // Control from the classifier to one hold counter.
    typedef struct packed {
        logic en;
        logic pressed;
        logic hold;
        logic load;
    } t_cnt_ctrl;

    // Compare results of one hold counter against the threshold.
    typedef struct packed {
        logic nonzero;
        logic below_th;
        logic at_th;
    } t_cnt_status;

endpackage

/* rtl/three_key_press_classifier.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_key_press_classifier
// Per-tick short/long press classifier for the mode, select and increment
// keys, with held long-press and auto-repeat events.
// ----------------------------------------------------------------------------
// One scan word is accepted per clock unless the output stalls: the word is
// captured in an input register, then the three hold counters and the event
// decode act on it and the events land in the output register, which takes
// the next word as the input register refills. The block only stalls when
// the output word is not taken. The user must write the thresholds over the
// APB port only while the stream is idle; the block does not enforce this.
module three_key_press_classifier #(
    parameter int COUNT_WIDTH = tkpc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Scan word, bit 0 up: mode_key_pressed, inc_key_pressed,
    // select_key_pressed, ui_mode[1:0], clock_setting, keys_locked, zero pad.
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [tkpc_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // Event word, bit 0 up: mode_key_event[2:0], select_key_event[1:0],
    // inc_key_event[1:0], zero pad.
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [tkpc_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // APB configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tkpc_pkg::PADDR_W-1:0]        paddr,
    input  logic [tkpc_pkg::PDATA_W-1:0]        pwdata,
    output logic [tkpc_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);

    logic [tkpc_pkg::CFG_W-1:0] r_long_threshold;
    logic [tkpc_pkg::CFG_W-1:0] r_repeat_reload;
    logic                       w_cfg_wr;

    logic                 r_in_valid;
    tkpc_pkg::t_scan_item r_in;
    logic                 r_out_valid;
    tkpc_pkg::t_events    r_out;
    tkpc_pkg::t_events    n_out;
    logic                 w_adv;

    tkpc_pkg::t_cnt_ctrl   w_mode_ctrl, w_sel_ctrl, w_inc_ctrl;
    tkpc_pkg::t_cnt_status w_mode_st, w_sel_st, w_inc_st;
    logic                  w_mode_short, w_sel_short, w_sel_long, w_inc_short, w_inc_long;

    // ---------------- configuration ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_threshold <= tkpc_pkg::LONG_THRESHOLD_RST;
            r_repeat_reload  <= tkpc_pkg::REPEAT_RELOAD_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr)
                tkpc_pkg::ADDR_LONG_THRESHOLD: r_long_threshold <= pwdata[tkpc_pkg::CFG_W-1:0];
                tkpc_pkg::ADDR_REPEAT_RELOAD:  r_repeat_reload  <= pwdata[tkpc_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            tkpc_pkg::ADDR_LONG_THRESHOLD: prdata = tkpc_pkg::PDATA_W'(r_long_threshold);
            tkpc_pkg::ADDR_REPEAT_RELOAD:  prdata = tkpc_pkg::PDATA_W'(r_repeat_reload);
            default:                       prdata = '0;
        endcase
    end

    // ---------------- stream stages ----------------
    assign w_adv           = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in.mode_key_pressed   <= i_s_axis_tdata[0];
            r_in.inc_key_pressed    <= i_s_axis_tdata[1];
            r_in.select_key_pressed <= i_s_axis_tdata[2];
            r_in.ui_mode            <= i_s_axis_tdata[4:3];
            r_in.clock_setting      <= i_s_axis_tdata[5];
            r_in.keys_locked        <= i_s_axis_tdata[6];
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out.inc_key_event, r_out.select_key_event,
                              r_out.mode_key_event};

    // ---------------- hold counters ----------------
    tkpc_hold_counter #(.COUNT_WIDTH(COUNT_WIDTH)) u_mode_cnt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_mode_ctrl),
        .i_threshold(r_long_threshold),
        .i_reload   (r_repeat_reload),
        .o_status   (w_mode_st)
    );

    tkpc_hold_counter #(.COUNT_WIDTH(COUNT_WIDTH)) u_sel_cnt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_sel_ctrl),
        .i_threshold(r_long_threshold),
        .i_reload   (r_repeat_reload),
        .o_status   (w_sel_st)
    );

    tkpc_hold_counter #(.COUNT_WIDTH(COUNT_WIDTH)) u_inc_cnt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_inc_ctrl),
        .i_threshold(r_long_threshold),
        .i_reload   (r_repeat_reload),
        .o_status   (w_inc_st)
    );

    // ---------------- event decode ----------------
    assign w_mode_short = w_mode_st.nonzero && w_mode_st.below_th;
    assign w_sel_short  = w_sel_st.nonzero && w_sel_st.below_th;
    assign w_sel_long   = w_sel_st.nonzero && !w_sel_st.below_th;
    assign w_inc_short  = w_inc_st.nonzero && w_inc_st.below_th;
    assign w_inc_long   = w_inc_st.nonzero && !w_inc_st.below_th;

    always_comb begin
        n_out.mode_key_event   = tkpc_pkg::MEV_NONE;
        n_out.select_key_event = tkpc_pkg::SEV_NONE;
        n_out.inc_key_event    = tkpc_pkg::IEV_NONE;

        w_mode_ctrl = '{en: w_adv, pressed: r_in.mode_key_pressed, hold: 1'b0, load: 1'b0};
        w_sel_ctrl  = '{en: w_adv, pressed: r_in.select_key_pressed, hold: 1'b0, load: 1'b0};
        w_inc_ctrl  = '{en: w_adv, pressed: r_in.inc_key_pressed, hold: 1'b0, load: 1'b0};

        // Mode: unlocked short release switches mode; clock/power hold fires.
        if (!r_in.mode_key_pressed) begin
            if (w_mode_short && !r_in.keys_locked) begin
                n_out.mode_key_event = tkpc_pkg::MEV_SWITCH_MODE;
            end
        end else if (w_mode_st.at_th) begin
            if (r_in.ui_mode == tkpc_pkg::MODE_CLOCK) begin
                n_out.mode_key_event = r_in.clock_setting ? tkpc_pkg::MEV_LEAVE_SETTING
                                                          : tkpc_pkg::MEV_ENTER_SETTING;
            end else if (r_in.ui_mode == tkpc_pkg::MODE_POWER) begin
                n_out.mode_key_event = tkpc_pkg::MEV_POWER_TOGGLE;
            end
        end

        if (!r_in.select_key_pressed) begin
            if (r_in.ui_mode == tkpc_pkg::MODE_CLOCK && w_sel_short) begin
                n_out.select_key_event = tkpc_pkg::SEV_CHOOSE_DIGIT;
            end else if (r_in.ui_mode == tkpc_pkg::MODE_TIMER && w_sel_short) begin
                n_out.select_key_event = tkpc_pkg::SEV_DISPLAY_MODE;
            end else if (r_in.ui_mode == tkpc_pkg::MODE_TIMER && w_sel_long) begin
                n_out.select_key_event = tkpc_pkg::SEV_COUNT_DIR;
            end
        end

        if (!r_in.inc_key_pressed) begin
            if (r_in.ui_mode == tkpc_pkg::MODE_CLOCK && w_inc_short) begin
                n_out.inc_key_event = tkpc_pkg::IEV_INC_DIGIT;
            end else if (r_in.ui_mode == tkpc_pkg::MODE_TIMER && w_inc_short) begin
                n_out.inc_key_event = tkpc_pkg::IEV_TIMER_START;
            end else if (r_in.ui_mode == tkpc_pkg::MODE_TIMER && w_inc_long) begin
                n_out.inc_key_event = tkpc_pkg::IEV_TIMER_RESET;
            end
        end else if (r_in.ui_mode == tkpc_pkg::MODE_CLOCK && w_inc_st.at_th) begin
            // Auto-repeat while setting the clock; otherwise the count parks.
            if (r_in.clock_setting) begin
                n_out.inc_key_event = tkpc_pkg::IEV_INC_DIGIT;
                w_inc_ctrl.load     = 1'b1;
            end else begin
                w_inc_ctrl.hold     = 1'b1;
            end
        end
    end

    // ---------------- assertions ----------------
    a_out_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_adv_gives_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> o_m_axis_tvalid)
        else $error("processed word did not reach the output register");

    a_stalled_input_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid && $stable(r_in))
        else $error("stalled scan word lost");

    a_release_clears_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && !r_in.mode_key_pressed |=> !w_mode_st.nonzero)
        else $error("mode key counter not cleared on release");

    a_inc_load_only_clock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_inc_ctrl.load |-> (r_in.ui_mode == tkpc_pkg::MODE_CLOCK) &&
                            (n_out.inc_key_event == tkpc_pkg::IEV_INC_DIGIT))
        else $error("increment reload without auto-repeat event");

endmodule

/* rtl/tkpc_hold_counter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkpc_hold_counter
// Saturating hold counter of one key with clear on release, optional reload
// and hold, and its compares against the long-press threshold.
// ----------------------------------------------------------------------------
module tkpc_hold_counter #(
    parameter int COUNT_WIDTH = tkpc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tkpc_pkg::t_cnt_ctrl        i_ctrl,
    input  logic [tkpc_pkg::CFG_W-1:0] i_threshold,
    input  logic [tkpc_pkg::CFG_W-1:0] i_reload,
    output tkpc_pkg::t_cnt_status      o_status
);

    localparam int CMP_W = (COUNT_WIDTH > tkpc_pkg::CFG_W) ? COUNT_WIDTH : tkpc_pkg::CFG_W;

    logic [COUNT_WIDTH-1:0] r_cnt;
    logic [COUNT_WIDTH-1:0] n_cnt;
    logic [CMP_W-1:0]       w_cnt_ext;
    logic [CMP_W-1:0]       w_th_ext;
    logic [CMP_W-1:0]       w_reload_ext;

    assign w_cnt_ext    = CMP_W'(r_cnt);
    assign w_th_ext     = CMP_W'(i_threshold);
    assign w_reload_ext = CMP_W'(i_reload);

    assign o_status.nonzero  = (r_cnt != '0);
    assign o_status.below_th = (w_cnt_ext < w_th_ext);
    assign o_status.at_th    = (w_cnt_ext == w_th_ext);

    always_comb begin
        n_cnt = r_cnt;
        if (i_ctrl.en) begin
            if (!i_ctrl.pressed) begin
                n_cnt = '0;
            end else if (i_ctrl.load) begin
                n_cnt = w_reload_ext[COUNT_WIDTH-1:0];
            end else if (!i_ctrl.hold && (r_cnt != '1)) begin
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

/* tb/sv/three_key_press_classifier_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_key_press_classifier_test
// Self-checking bench for the three-key press classifier. Scan words go in
// over the input stream and event words come back over the output stream.
// Both sides idle in random bursts except while no_idle is set. A
// cycle-accurate predictor of the hold counters gives the event word that
// each accepted scan word should cause. Thresholds are changed over APB
// between phases, and only once the stream has drained.
// ----------------------------------------------------------------------------
module three_key_press_classifier_test;

    localparam int CW          = tkpc_pkg::COUNT_WIDTH_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_s_axis_tvalid = 1'b0;
    logic                                o_s_axis_tready;
    logic [tkpc_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata = '0;
    logic                                o_m_axis_tvalid;
    logic                                i_m_axis_tready = 1'b0;
    logic [tkpc_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata;
    logic                                psel = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite = 1'b0;
    logic [tkpc_pkg::PADDR_W-1:0]        paddr = '0;
    logic [tkpc_pkg::PDATA_W-1:0]        pwdata = '0;
    logic [tkpc_pkg::PDATA_W-1:0]        prdata;
    logic                                pready;

    three_key_press_classifier dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Predictor state: the bench's own copy of the registers and counters.
    logic [tkpc_pkg::CFG_W-1:0] long_thr   = tkpc_pkg::LONG_THRESHOLD_RST;
    logic [tkpc_pkg::CFG_W-1:0] rep_reload = tkpc_pkg::REPEAT_RELOAD_RST;
    logic [CW-1:0]              mode_hold   = '0;
    logic [CW-1:0]              select_hold = '0;
    logic [CW-1:0]              inc_hold    = '0;

    tkpc_pkg::t_scan_item scan_queue[$];
    tkpc_pkg::t_events    expected_events[$];

    int err_count   = 0;
    int cycle_count = 0;
    int src_idle    = 0;
    int sink_idle   = 0;
    bit no_idle     = 1'b0;

    task automatic report_mismatch(input string msg);
        if (err_count < 40) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        err_count++;
    endtask

    function automatic logic [CW-1:0] hold_step(input logic [CW-1:0] c);
        return (c == {CW{1'b1}}) ? c : c + 1'b1;
    endfunction

    // Advances the three hold counters by one scan tick and returns the events.
    function automatic tkpc_pkg::t_events classify_tick(input tkpc_pkg::t_scan_item s);
        tkpc_pkg::t_events ev;
        logic              short_press;
        logic              long_press;
        ev = '{inc_key_event: tkpc_pkg::IEV_NONE, select_key_event: tkpc_pkg::SEV_NONE,
               mode_key_event: tkpc_pkg::MEV_NONE};

        if (!s.mode_key_pressed) begin
            if (mode_hold != '0 && mode_hold < long_thr && !s.keys_locked) begin
                ev.mode_key_event = tkpc_pkg::MEV_SWITCH_MODE;
            end
            mode_hold = '0;
        end else begin
            if (mode_hold == long_thr && s.ui_mode == tkpc_pkg::MODE_CLOCK) begin
                ev.mode_key_event = s.clock_setting ? tkpc_pkg::MEV_LEAVE_SETTING
                                                    : tkpc_pkg::MEV_ENTER_SETTING;
            end else if (mode_hold == long_thr && s.ui_mode == tkpc_pkg::MODE_POWER) begin
                ev.mode_key_event = tkpc_pkg::MEV_POWER_TOGGLE;
            end
            mode_hold = hold_step(mode_hold);
        end

        if (!s.select_key_pressed) begin
            short_press = (select_hold != '0) && (select_hold < long_thr);
            long_press  = (select_hold != '0) && (select_hold >= long_thr);
            if (s.ui_mode == tkpc_pkg::MODE_CLOCK && short_press) begin
                ev.select_key_event = tkpc_pkg::SEV_CHOOSE_DIGIT;
            end else if (s.ui_mode == tkpc_pkg::MODE_TIMER && short_press) begin
                ev.select_key_event = tkpc_pkg::SEV_DISPLAY_MODE;
            end else if (s.ui_mode == tkpc_pkg::MODE_TIMER && long_press) begin
                ev.select_key_event = tkpc_pkg::SEV_COUNT_DIR;
            end
            select_hold = '0;
        end else begin
            select_hold = hold_step(select_hold);
        end

        if (!s.inc_key_pressed) begin
            short_press = (inc_hold != '0) && (inc_hold < long_thr);
            long_press  = (inc_hold != '0) && (inc_hold >= long_thr);
            if (s.ui_mode == tkpc_pkg::MODE_CLOCK && short_press) begin
                ev.inc_key_event = tkpc_pkg::IEV_INC_DIGIT;
            end else if (s.ui_mode == tkpc_pkg::MODE_TIMER && short_press) begin
                ev.inc_key_event = tkpc_pkg::IEV_TIMER_START;
            end else if (s.ui_mode == tkpc_pkg::MODE_TIMER && long_press) begin
                ev.inc_key_event = tkpc_pkg::IEV_TIMER_RESET;
            end
            inc_hold = '0;
        end else if (s.ui_mode == tkpc_pkg::MODE_CLOCK && inc_hold == long_thr) begin
            // Auto-repeat only while setting the clock; otherwise the count parks.
            if (s.clock_setting) begin
                ev.inc_key_event = tkpc_pkg::IEV_INC_DIGIT;
                inc_hold = CW'(rep_reload);
            end
        end else begin
            inc_hold = hold_step(inc_hold);
        end
        return ev;
    endfunction

    function automatic void push_scan(input bit mk, input bit ik, input bit sk,
                                      input logic [1:0] md, input bit st, input bit lk);
        scan_queue.push_back('{keys_locked: lk, clock_setting: st, ui_mode: md,
                               select_key_pressed: sk, inc_key_pressed: ik,
                               mode_key_pressed: mk});
    endfunction

    // Each key toggles between press runs, whose lengths cluster around the
    // threshold, and short release runs; a few words are pure noise.
    task automatic gen_random(input int n, input int thr);
        int         left [3];
        bit         lvl  [3];
        logic [1:0] md;
        bit         st;
        bit         lk;
        int         k;
        int         lo;
        md = tkpc_pkg::MODE_CLOCK;
        st = 1'b0;
        lk = 1'b0;
        for (k = 0; k < 3; k++) begin
            left[k] = 0;
            lvl[k]  = 1'b0;
        end
        lo = (thr > 1) ? thr - 1 : 1;
        repeat (n) begin
            for (k = 0; k < 3; k++) begin
                if (left[k] == 0) begin
                    lvl[k] = !lvl[k];
                    if (lvl[k]) begin
                        case ($urandom_range(0, 3))
                            0:       left[k] = $urandom_range(1, lo);
                            1:       left[k] = $urandom_range(lo, thr + 1);
                            2:       left[k] = $urandom_range(thr + 1, 2 * thr + 3);
                            default: left[k] = $urandom_range(1, 3);
                        endcase
                    end else begin
                        left[k] = $urandom_range(1, 5);
                    end
                end
                left[k]--;
            end
            if ($urandom_range(0, 24) == 0) md = 2'($urandom_range(0, 2));
            if ($urandom_range(0, 19) == 0) st = !st;
            if ($urandom_range(0, 19) == 0) lk = !lk;
            if ($urandom_range(0, 11) == 0) begin
                push_scan(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 2'($urandom_range(0, 2)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
                push_scan(lvl[0], lvl[1], lvl[2], md, st, lk);
            end
        end
    endtask

    // The predictor's copy changes at the edge where the block takes the write.
    task automatic cfg_write(input logic [tkpc_pkg::PADDR_W-1:0] addr,
                             input logic [tkpc_pkg::CFG_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {16'($urandom), val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == tkpc_pkg::ADDR_LONG_THRESHOLD) begin
            long_thr = val;
        end else begin
            rep_reload = val;
        end
    endtask

    task automatic drain();
        while (scan_queue.size() != 0 || i_s_axis_tvalid || expected_events.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin : scan_driver
        tkpc_pkg::t_events ev;
        bit                taken;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            taken = i_s_axis_tvalid && o_s_axis_tready;
            if (taken) begin
                ev = classify_tick(tkpc_pkg::t_scan_item'(i_s_axis_tdata[6:0]));
                expected_events.push_back(ev);
            end
            if (!i_s_axis_tvalid || taken) begin
                if (src_idle > 0) begin
                    src_idle--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (scan_queue.size() != 0) begin
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= {1'b0, scan_queue.pop_front()};
                    if (!no_idle && $urandom_range(0, 9) == 0) begin
                        src_idle = $urandom_range(1, 16);
                    end
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : event_monitor
        tkpc_pkg::t_events got;
        tkpc_pkg::t_events want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = tkpc_pkg::t_events'(o_m_axis_tdata[6:0]);
                if (expected_events.size() == 0) begin
                    report_mismatch($sformatf("event word %h with none expected",
                                              o_m_axis_tdata));
                end else begin
                    want = expected_events.pop_front();
                    if (got.mode_key_event !== want.mode_key_event) begin
                        report_mismatch($sformatf("mode_key_event %0d, expected %0d",
                                                  got.mode_key_event, want.mode_key_event));
                    end
                    if (got.select_key_event !== want.select_key_event) begin
                        report_mismatch($sformatf("select_key_event %0d, expected %0d",
                                                  got.select_key_event, want.select_key_event));
                    end
                    if (got.inc_key_event !== want.inc_key_event) begin
                        report_mismatch($sformatf("inc_key_event %0d, expected %0d",
                                                  got.inc_key_event, want.inc_key_event));
                    end
                    if (o_m_axis_tdata[7] !== 1'b0) begin
                        report_mismatch("pad bit of event word not zero");
                    end
                end
            end
            if (sink_idle > 0) begin
                sink_idle--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
                if (!no_idle && $urandom_range(0, 9) == 0) begin
                    sink_idle = $urandom_range(1, 16);
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : sequencer
        int thr;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset thresholds: idle tick and one short mode press.
        push_scan(0, 0, 0, tkpc_pkg::MODE_CLOCK, 0, 0);
        push_scan(1, 0, 0, tkpc_pkg::MODE_CLOCK, 0, 0);
        push_scan(0, 0, 0, tkpc_pkg::MODE_CLOCK, 0, 0);
        drain();

        // Small threshold so that every held and long event shows up quickly.
        cfg_write(tkpc_pkg::ADDR_LONG_THRESHOLD, 16'd3);
        cfg_write(tkpc_pkg::ADDR_REPEAT_RELOAD, 16'd1);
        // Held mode key enters setting; the increment count parks at threshold.
        repeat (4) push_scan(1, 1, 0, tkpc_pkg::MODE_CLOCK, 0, 0);
        push_scan(0, 0, 0, tkpc_pkg::MODE_CLOCK, 0, 0);
        // Held mode key leaves setting; increment auto-repeats and reloads.
        repeat (6) push_scan(1, 1, 1, tkpc_pkg::MODE_CLOCK, 1, 0);
        push_scan(0, 0, 0, tkpc_pkg::MODE_CLOCK, 1, 0);
        // Power toggle while held, then long releases in timer mode.
        repeat (4) push_scan(1, 1, 1, tkpc_pkg::MODE_POWER, 1, 1);
        push_scan(0, 0, 0, tkpc_pkg::MODE_TIMER, 1, 1);
        // Short presses in timer mode, then in clock mode with the keys locked.
        push_scan(1, 1, 1, tkpc_pkg::MODE_TIMER, 0, 0);
        push_scan(0, 0, 0, tkpc_pkg::MODE_TIMER, 0, 0);
        push_scan(1, 1, 1, tkpc_pkg::MODE_CLOCK, 0, 1);
        push_scan(0, 0, 0, tkpc_pkg::MODE_CLOCK, 0, 1);
        drain();

        cfg_write(tkpc_pkg::ADDR_LONG_THRESHOLD, tkpc_pkg::LONG_THRESHOLD_RST);
        cfg_write(tkpc_pkg::ADDR_REPEAT_RELOAD, tkpc_pkg::REPEAT_RELOAD_RST);
        gen_random(120, int'(tkpc_pkg::LONG_THRESHOLD_RST));
        drain();

        cfg_write(tkpc_pkg::ADDR_LONG_THRESHOLD, 16'd1);
        cfg_write(tkpc_pkg::ADDR_REPEAT_RELOAD, 16'd0);
        gen_random(120, 1);
        drain();

        // Threshold and reload one below the maximum: every press here is short.
        no_idle = 1'b1;
        cfg_write(tkpc_pkg::ADDR_LONG_THRESHOLD, 16'd65534);
        cfg_write(tkpc_pkg::ADDR_REPEAT_RELOAD, 16'd65534);
        repeat (12) push_scan(1, 1, 1, tkpc_pkg::MODE_POWER, 0, 0);
        push_scan(0, 0, 0, tkpc_pkg::MODE_TIMER, 0, 0);
        drain();
        no_idle = 1'b0;

        // Reload above the threshold: the repeat count runs on past it.
        cfg_write(tkpc_pkg::ADDR_LONG_THRESHOLD, 16'd6);
        cfg_write(tkpc_pkg::ADDR_REPEAT_RELOAD, 16'd40);
        gen_random(120, 6);
        drain();

        repeat (2) begin
            thr = $urandom_range(2, 20);
            cfg_write(tkpc_pkg::ADDR_LONG_THRESHOLD, tkpc_pkg::CFG_W'(thr));
            cfg_write(tkpc_pkg::ADDR_REPEAT_RELOAD,
                      tkpc_pkg::CFG_W'($urandom_range(0, thr - 1)));
            gen_random(110, thr);
            drain();
        end

        no_idle = 1'b1;
        cfg_write(tkpc_pkg::ADDR_LONG_THRESHOLD, 16'd12);
        cfg_write(tkpc_pkg::ADDR_REPEAT_RELOAD, 16'd7);
        gen_random(120, 12);
        drain();

        repeat (8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* three_key_press_classifier.f */
rtl/tkpc_pkg.sv
rtl/tkpc_hold_counter.sv
rtl/three_key_press_classifier.sv
tb/sv/three_key_press_classifier_test.sv
